// File: hw/rtl/incdir_pkg.sv
// ----------------------------------------------------------------------------
// incdir_pkg
// Shared payload types for the include directive recognizer.
// ----------------------------------------------------------------------------
`default_nettype none

package incdir_pkg;

	// One text byte, or a flush that ends the line without a character.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       flush;
	} text_item_t;

	// One result per input transaction.
	typedef struct packed {
		logic        path_byte_valid;
		logic [7:0]  path_byte;
		logic        line_done;
		logic        is_include;
		logic        angle_form;
		logic [9:0]  path_length;
		logic [19:0] line_number;
	} line_result_t;

	localparam int unsigned PATH_LEN_CAP = 1023;
	localparam int unsigned LINE_NUM_CAP = 1048575;

endpackage

`default_nettype wire

// File: hw/rtl/incdir_if.sv
// ----------------------------------------------------------------------------
// incdir_in_if / incdir_out_if
// Valid/ready channels for text items and line results.
// ----------------------------------------------------------------------------
`default_nettype none

interface incdir_in_if
	import incdir_pkg::*;
	();
	logic       valid;
	logic       ready;
	text_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface incdir_out_if
	import incdir_pkg::*;
	();
	logic         valid;
	logic         ready;
	line_result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/include_directive_recognizer_top.sv
// ----------------------------------------------------------------------------
// include_directive_recognizer_top
// Streams text bytes through an include-line parser, one result per byte.
// ----------------------------------------------------------------------------
// Usage:
//   text_in    - sink channel; each transaction carries one text byte or a
//                flush. A newline byte or a flush ends the current line.
//   result_out - source channel; exactly one result transaction per input
//                transaction, in order. Path characters come out as they are
//                seen (tentative); the line verdict, bracket kind, path
//                length and line number come with the byte that ends a line.
// Pipeline: an accepted byte is captured in the input register; its result
//   is loaded into the result register, from which result_out presents it.
// Throughput: one transaction per cycle in both directions while result_out
//   is ready. The parser state machine updates once per byte in the stage
//   between the input register and the result register.
// Stall: when result_out is not ready the result register holds, the input
//   register keeps its byte, and text_in drops ready only once both are full.
// Reset: arst_n clears both stage valids, puts the parser at line start and
//   sets the line counter to one. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module include_directive_recognizer_top
	import incdir_pkg::*;
#(
	parameter int unsigned     PATH_COUNT_MAX = 1023,
	parameter longint unsigned LINE_COUNT_MAX = 1048575
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	incdir_in_if.sink     text_in,
	incdir_out_if.source  result_out
);

	text_item_t   item_s1;
	logic         vld_s1;
	line_result_t res_s2;
	logic         vld_s2;
	line_result_t res_comb;
	logic         advance;

	// Advance the parser when a byte waits and the result register frees up.
	assign advance       = vld_s1 && (!vld_s2 || result_out.ready);
	assign text_in.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (text_in.ready) begin
			vld_s1 <= text_in.valid;
		end
	end

	// Input register: capture the byte on each accepted transaction.
	always_ff @(posedge clk) begin
		if (text_in.valid && text_in.ready)
			item_s1 <= text_in.payload;
	end

	incdir_core #(
		.PATH_COUNT_MAX (PATH_COUNT_MAX),
		.LINE_COUNT_MAX (LINE_COUNT_MAX)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (result_out.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	// Result register: load on advance, hold while the receiver stalls.
	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_comb;
	end

	assign result_out.valid   = vld_s2;
	assign result_out.payload = res_s2;

endmodule

`default_nettype wire

// File: hw/rtl/incdir_core.sv
// ----------------------------------------------------------------------------
// incdir_core
// Line parser state machine: phase, keyword position, counters, verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module incdir_core
	import incdir_pkg::*;
#(
	parameter int unsigned       PATH_COUNT_MAX = 1023,
	parameter longint unsigned   LINE_COUNT_MAX = 1048575
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire text_item_t    item,
	output line_result_t       result
);

	localparam int PW  = $clog2(longint'(PATH_COUNT_MAX) + 1);
	localparam int LW  = $clog2(LINE_COUNT_MAX + 64'd1);
	localparam int PWX = (PW > 10) ? PW : 10;
	localparam int LWX = (LW > 20) ? LW : 20;

	localparam logic [3:0] PH_LEAD        = 4'd0;
	localparam logic [3:0] PH_AFTER_HASH  = 4'd1;
	localparam logic [3:0] PH_KEYWORD     = 4'd2;
	localparam logic [3:0] PH_AFTER_KW    = 4'd3;
	localparam logic [3:0] PH_PATH        = 4'd4;
	localparam logic [3:0] PH_AFTER_PATH  = 4'd5;
	localparam logic [3:0] PH_SLASH       = 4'd6;
	localparam logic [3:0] PH_LINE_CMT    = 4'd7;
	localparam logic [3:0] PH_BLOCK       = 4'd8;
	localparam logic [3:0] PH_BLOCK_STAR  = 4'd9;
	localparam logic [3:0] PH_AFTER_BLOCK = 4'd10;
	localparam logic [3:0] PH_REJECT      = 4'd11;

	localparam logic [7:0] CH_NL     = 8'd10;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [2:0] KW_LEN    = 3'd7;

	function automatic logic [7:0] kw_char(input logic [2:0] idx);
		case (idx)
			3'd0:    kw_char = 8'h69; // i
			3'd1:    kw_char = 8'h6E; // n
			3'd2:    kw_char = 8'h63; // c
			3'd3:    kw_char = 8'h6C; // l
			3'd4:    kw_char = 8'h75; // u
			3'd5:    kw_char = 8'h64; // d
			3'd6:    kw_char = 8'h65; // e
			default: kw_char = 8'h00;
		endcase
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		is_ws = (c == 8'd32) || (c == 8'd9) || (c == 8'd13) || (c == 8'd11) || (c == 8'd12);
	endfunction

	logic [3:0]    phase_q, phase_d;
	logic [2:0]    kw_idx_q, kw_idx_d;
	logic          angle_q, angle_d;
	logic [PW-1:0] path_cnt_q, path_cnt_d;
	logic [LW-1:0] line_cnt_q, line_cnt_d;

	logic [PWX-1:0] path_cnt_x;
	logic [LWX-1:0] line_cnt_x;
	logic [7:0]     c;
	logic           line_end;
	logic           ok;

	assign c          = item.text_byte;
	assign line_end   = item.flush || (c == CH_NL);
	assign path_cnt_x = PWX'(path_cnt_q);
	assign line_cnt_x = LWX'(line_cnt_q);
	assign ok         = (phase_q == PH_AFTER_PATH) || (phase_q == PH_LINE_CMT) ||
	                    (phase_q == PH_AFTER_BLOCK);

	always_comb begin
		phase_d    = phase_q;
		kw_idx_d   = kw_idx_q;
		angle_d    = angle_q;
		path_cnt_d = path_cnt_q;
		line_cnt_d = line_cnt_q;
		result     = '0;

		if (line_end) begin
			result.line_done  = 1'b1;
			result.is_include = ok;
			if (ok) begin
				result.angle_form  = angle_q;
				result.path_length = (path_cnt_x > PWX'(PATH_LEN_CAP)) ?
				                     10'(PATH_LEN_CAP) : path_cnt_x[9:0];
			end
			result.line_number = (line_cnt_x > LWX'(LINE_NUM_CAP)) ?
			                     20'(LINE_NUM_CAP) : line_cnt_x[19:0];
			if (line_cnt_q != LW'(LINE_COUNT_MAX))
				line_cnt_d = line_cnt_q + 1'b1;
			// clear per-line state
			phase_d    = PH_LEAD;
			kw_idx_d   = '0;
			angle_d    = 1'b0;
			path_cnt_d = '0;
		end else begin
			unique case (phase_q)
				PH_LEAD: begin
					if (c == CH_HASH) phase_d = PH_AFTER_HASH;
					else if (!is_ws(c)) phase_d = PH_REJECT;
				end
				PH_AFTER_HASH: begin
					if (c == kw_char(3'd0)) begin
						kw_idx_d = 3'd1;
						phase_d  = PH_KEYWORD;
					end else if (!is_ws(c)) begin
						phase_d = PH_REJECT;
					end
				end
				PH_KEYWORD: begin
					if (kw_idx_q < KW_LEN && c == kw_char(kw_idx_q)) begin
						kw_idx_d = kw_idx_q + 3'd1;
						if (kw_idx_q + 3'd1 == KW_LEN) phase_d = PH_AFTER_KW;
					end else begin
						phase_d = PH_REJECT;
					end
				end
				PH_AFTER_KW: begin
					if (c == CH_QUOTE) begin
						angle_d = 1'b0;
						phase_d = PH_PATH;
					end else if (c == CH_LT) begin
						angle_d = 1'b1;
						phase_d = PH_PATH;
					end else if (!is_ws(c)) begin
						phase_d = PH_REJECT;
					end
				end
				PH_PATH: begin
					if (c == (angle_q ? CH_GT : CH_QUOTE)) begin
						phase_d = PH_AFTER_PATH;
					end else begin
						result.path_byte_valid = 1'b1;
						result.path_byte       = c;
						if (path_cnt_q != PW'(PATH_COUNT_MAX))
							path_cnt_d = path_cnt_q + 1'b1;
					end
				end
				PH_AFTER_PATH: begin
					if (c == CH_SLASH) phase_d = PH_SLASH;
					else if (!is_ws(c)) phase_d = PH_REJECT;
				end
				PH_SLASH: begin
					if (c == CH_SLASH) phase_d = PH_LINE_CMT;
					else if (c == CH_STAR) phase_d = PH_BLOCK;
					else phase_d = PH_REJECT;
				end
				PH_LINE_CMT: begin
					phase_d = PH_LINE_CMT;
				end
				PH_BLOCK: begin
					if (c == CH_STAR) phase_d = PH_BLOCK_STAR;
				end
				PH_BLOCK_STAR: begin
					if (c == CH_SLASH) phase_d = PH_AFTER_BLOCK;
					else if (c != CH_STAR) phase_d = PH_BLOCK;
				end
				PH_AFTER_BLOCK: begin
					if (!is_ws(c)) phase_d = PH_REJECT;
				end
				default: begin
					phase_d = PH_REJECT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LEAD;
			kw_idx_q   <= '0;
			angle_q    <= 1'b0;
			path_cnt_q <= '0;
			line_cnt_q <= LW'(1);
		end else if (step) begin
			phase_q    <= phase_d;
			kw_idx_q   <= kw_idx_d;
			angle_q    <= angle_d;
			path_cnt_q <= path_cnt_d;
			line_cnt_q <= line_cnt_d;
		end
	end

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb - include directive recognizer testbench
// Streams text through the recognizer and predicts one result per byte with
// a line scanner of its own. A short stimulus table opens the run. Random
// lines follow, about half of them well-formed include directives. The run ends
// with a stretch of back-to-back flushes and a few lines, all without idling.
// Both channels stall in random bursts until that final, idle-free stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import incdir_pkg::*;

	// Counter limits of the instance, matched by the line scanner below.
	localparam int unsigned     PATH_COUNT_LIMIT = 1023;
	localparam longint unsigned LINE_COUNT_LIMIT = 1048575;
	localparam int unsigned     CYCLE_LIMIT      = 400000;
	localparam int unsigned     RANDOM_ITEMS     = 1300;
	localparam int unsigned     FINAL_FLUSHES    = 32;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_VT      = 8'h0B;
	localparam logic [7:0] CH_FF      = 8'h0C;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_LT      = 8'h3C;
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [55:0] KEYWORD   = "include";

	// Where the scanner stands within the current line.
	typedef enum logic [3:0] {
		SCAN_LEAD,
		SCAN_AFTER_HASH,
		SCAN_KEYWORD,
		SCAN_AFTER_KW,
		SCAN_PATH,
		SCAN_AFTER_PATH,
		SCAN_SLASH,
		SCAN_LINE_CMT,
		SCAN_BLOCK,
		SCAN_BLOCK_STAR,
		SCAN_AFTER_BLOCK,
		SCAN_REJECT
	} scan_phase_e;

	// One row of the opening stimulus: pinned rows carry a hand-written result.
	typedef struct {
		text_item_t   item;
		bit           pinned;
		line_result_t result;
	} stim_row_t;

	localparam line_result_t PREDICTED = '0;

	logic clk = 1'b0;
	logic arst_n;

	incdir_in_if  text_in ();
	incdir_out_if result_out ();

	include_directive_recognizer_top #(
		.PATH_COUNT_MAX(PATH_COUNT_LIMIT),
		.LINE_COUNT_MAX(LINE_COUNT_LIMIT)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_in   (text_in),
		.result_out(result_out)
	);

	always #5 clk = ~clk;

	// Scanner state, advanced once per accepted text transaction.
	scan_phase_e     scan_phase;
	int unsigned     kw_matched;
	bit              close_angle;
	int unsigned     path_chars;
	longint unsigned line_no;

	line_result_t awaited_results [$];
	int unsigned  mismatch_count;

	// Travel alongside the payload so the checker knows a pinned row.
	bit           row_pinned;
	line_result_t row_pinned_result;

	bit          gaps_on;
	int unsigned items_sent;
	logic [7:0]  line_text [$];
	stim_row_t   opening_rows [26];

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
	endfunction

	// Predict the result of one text transaction and advance the scanner.
	function automatic line_result_t scan_text_item(text_item_t it);
		line_result_t r;
		logic [7:0]   c;
		bit           good;
		r = '0;
		c = it.text_byte;
		if (it.flush || c == CH_NEWLINE) begin
			good = scan_phase == SCAN_AFTER_PATH || scan_phase == SCAN_LINE_CMT ||
				scan_phase == SCAN_AFTER_BLOCK;
			r.line_done  = 1'b1;
			r.is_include = good;
			if (good) begin
				r.angle_form  = close_angle;
				r.path_length = 10'(path_chars > PATH_LEN_CAP ? PATH_LEN_CAP : path_chars);
			end
			r.line_number = 20'(line_no > LINE_NUM_CAP ? LINE_NUM_CAP : line_no);
			if (line_no < LINE_COUNT_LIMIT)
				line_no++;
			scan_phase  = SCAN_LEAD;
			kw_matched  = 0;
			close_angle = 1'b0;
			path_chars  = 0;
			return r;
		end
		case (scan_phase)
			SCAN_LEAD: begin
				if (c == CH_HASH)
					scan_phase = SCAN_AFTER_HASH;
				else if (!is_blank(c))
					scan_phase = SCAN_REJECT;
			end
			SCAN_AFTER_HASH: begin
				if (c == KEYWORD[55:48]) begin
					kw_matched = 1;
					scan_phase = SCAN_KEYWORD;
				end else if (!is_blank(c)) begin
					scan_phase = SCAN_REJECT;
				end
			end
			SCAN_KEYWORD: begin
				if (kw_matched < 7 && c == KEYWORD[8 * (6 - kw_matched) +: 8]) begin
					kw_matched++;
					if (kw_matched >= 7)
						scan_phase = SCAN_AFTER_KW;
				end else begin
					scan_phase = SCAN_REJECT;
				end
			end
			SCAN_AFTER_KW: begin
				if (c == CH_QUOTE) begin
					close_angle = 1'b0;
					scan_phase  = SCAN_PATH;
				end else if (c == CH_LT) begin
					close_angle = 1'b1;
					scan_phase  = SCAN_PATH;
				end else if (!is_blank(c)) begin
					scan_phase = SCAN_REJECT;
				end
			end
			SCAN_PATH: begin
				if (c == (close_angle ? CH_GT : CH_QUOTE)) begin
					scan_phase = SCAN_AFTER_PATH;
				end else begin
					r.path_byte_valid = 1'b1;
					r.path_byte       = c;
					if (path_chars < PATH_COUNT_LIMIT)
						path_chars++;
				end
			end
			SCAN_AFTER_PATH: begin
				if (c == CH_SLASH)
					scan_phase = SCAN_SLASH;
				else if (!is_blank(c))
					scan_phase = SCAN_REJECT;
			end
			SCAN_SLASH: begin
				if (c == CH_SLASH)
					scan_phase = SCAN_LINE_CMT;
				else if (c == CH_STAR)
					scan_phase = SCAN_BLOCK;
				else
					scan_phase = SCAN_REJECT;
			end
			SCAN_LINE_CMT: ;
			SCAN_BLOCK: begin
				if (c == CH_STAR)
					scan_phase = SCAN_BLOCK_STAR;
			end
			SCAN_BLOCK_STAR: begin
				if (c == CH_SLASH)
					scan_phase = SCAN_AFTER_BLOCK;
				else if (c != CH_STAR)
					scan_phase = SCAN_BLOCK;
			end
			SCAN_AFTER_BLOCK: begin
				if (!is_blank(c))
					scan_phase = SCAN_REJECT;
			end
			default: scan_phase = SCAN_REJECT;
		endcase
		return r;
	endfunction

	function automatic line_result_t line_verdict(bit inc, bit angle, int unsigned len,
			int unsigned num);
		line_result_t r;
		r = '0;
		r.line_done   = 1'b1;
		r.is_include  = inc;
		r.angle_form  = angle;
		r.path_length = 10'(len);
		r.line_number = 20'(num);
		return r;
	endfunction

	task automatic check_field(string field, logic [19:0] want_v, logic [19:0] got_v);
		if (got_v !== want_v) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field,
				want_v, got_v);
		end
	endtask

	// Check results against the oldest expectation first, then record what the
	// text transaction of this edge will produce.
	always @(posedge clk) begin : result_check
		line_result_t want;
		line_result_t got;
		line_result_t fresh;
		if (arst_n) begin
			if (result_out.valid && result_out.ready) begin
				got = result_out.payload;
				if (awaited_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result, expected none, actual %h",
						$time, got);
				end else begin
					want = awaited_results.pop_front();
					check_field("path_byte_valid", 20'(want.path_byte_valid),
						20'(got.path_byte_valid));
					check_field("path_byte", 20'(want.path_byte), 20'(got.path_byte));
					check_field("line_done", 20'(want.line_done), 20'(got.line_done));
					check_field("is_include", 20'(want.is_include), 20'(got.is_include));
					check_field("angle_form", 20'(want.angle_form), 20'(got.angle_form));
					check_field("path_length", 20'(want.path_length),
						20'(got.path_length));
					check_field("line_number", want.line_number, got.line_number);
				end
			end
			if (text_in.valid && text_in.ready) begin
				fresh = scan_text_item(text_in.payload);
				awaited_results.push_back(row_pinned ? row_pinned_result : fresh);
			end
		end
	end

	// Result side: accept freely, with stall bursts while gaps are enabled.
	initial begin : result_sink
		int unsigned stall_left;
		stall_left = 0;
		result_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_out.ready <= (stall_left == 0);
			end else if (gaps_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 19);
				result_out.ready <= 1'b0;
			end else begin
				result_out.ready <= 1'b1;
			end
		end
	end

	// Offer one transaction and hold it until the edge that takes it.
	task automatic send_item(text_item_t it, bit pinned, line_result_t pinned_result);
		if (gaps_on && $urandom_range(0, 9) == 0) begin
			text_in.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		text_in.valid     <= 1'b1;
		text_in.payload   <= it;
		row_pinned        <= pinned;
		row_pinned_result <= pinned_result;
		@(posedge clk);
		while (!text_in.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_text(logic [7:0] c);
		send_item('{text_byte: c, flush: 1'b0}, 1'b0, PREDICTED);
	endtask

	task automatic send_flush(logic [7:0] c);
		send_item('{text_byte: c, flush: 1'b1}, 1'b0, PREDICTED);
	endtask

	// Drop valid and hold off until every outstanding result has arrived.
	task automatic drain_results();
		text_in.valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] any_blank();
		case ($urandom_range(0, 4))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			3: return CH_VT;
			default: return CH_FF;
		endcase
	endfunction

	function automatic logic [7:0] any_text_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_NEWLINE);
		return c;
	endfunction

	task automatic add_blanks(int unsigned most);
		repeat ($urandom_range(0, most))
			line_text.push_back(any_blank());
	endtask

	// Build a well-formed directive with random spacing, bracket kind and tail.
	task automatic compose_directive(int unsigned path_len);
		bit         angle;
		logic [7:0] closer;
		logic [7:0] c;
		angle  = 1'($urandom_range(0, 1));
		closer = angle ? CH_GT : CH_QUOTE;
		add_blanks(2);
		line_text.push_back(CH_HASH);
		add_blanks(2);
		for (int k = 0; k < 7; k++)
			line_text.push_back(KEYWORD[8 * (6 - k) +: 8]);
		add_blanks(2);
		line_text.push_back(angle ? CH_LT : CH_QUOTE);
		repeat (path_len) begin
			c = $urandom_range(0, 1) ? 8'($urandom_range(8'h21, 8'h7E)) : any_text_byte();
			line_text.push_back(c == closer ? CH_DOT : c);
		end
		line_text.push_back(closer);
		case ($urandom_range(0, 4))
			0: ;
			1: add_blanks(3);
			2: begin
				// line comment with arbitrary content
				add_blanks(2);
				line_text.push_back(CH_SLASH);
				line_text.push_back(CH_SLASH);
				repeat ($urandom_range(0, 5))
					line_text.push_back(any_text_byte());
			end
			3: begin
				// block comment; a stray early close leaves junk after it
				add_blanks(2);
				line_text.push_back(CH_SLASH);
				line_text.push_back(CH_STAR);
				repeat ($urandom_range(0, 4)) begin
					case ($urandom_range(0, 3))
						0: line_text.push_back(CH_STAR);
						1: line_text.push_back(CH_SLASH);
						2: line_text.push_back(CH_SPACE);
						default: line_text.push_back(any_text_byte());
					endcase
				end
				line_text.push_back(CH_STAR);
				line_text.push_back(CH_SLASH);
				add_blanks(2);
			end
			default: begin
				// the opening star cannot close the comment
				line_text.push_back(CH_SLASH);
				line_text.push_back(CH_STAR);
				line_text.push_back(CH_SLASH);
				add_blanks(1);
			end
		endcase
	endtask

	// Send the built line, then end it with a newline or a flush.
	task automatic send_line();
		foreach (line_text[i])
			send_text(line_text[i]);
		line_text.delete();
		if ($urandom_range(0, 3) == 0)
			send_flush(8'($urandom_range(0, 255)));
		else
			send_text(CH_NEWLINE);
	endtask

	task automatic random_line();
		int unsigned pick;
		int unsigned cut;
		line_text.delete();
		pick = $urandom_range(0, 19);
		if (pick < 10) begin
			compose_directive($urandom_range(0, 12));
		end else if (pick < 13) begin
			// truncate anywhere: partial keyword, unclosed path, lone slash or unclosed comment
			compose_directive($urandom_range(0, 12));
			cut = $urandom_range(0, line_text.size() - 1);
			while (line_text.size() > cut)
				void'(line_text.pop_back());
		end else if (pick < 15) begin
			compose_directive($urandom_range(0, 12));
			line_text[$urandom_range(0, line_text.size() - 1)] = any_text_byte();
		end else if (pick < 18) begin
			repeat ($urandom_range(0, 20))
				line_text.push_back(any_text_byte());
		end else begin
			add_blanks(4);
		end
		send_line();
	endtask

	// Run limit: end the run as failed if the stream never settles.
	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		int unsigned flushes_left;
		bit          long_sent;

		scan_phase     = SCAN_LEAD;
		kw_matched     = 0;
		close_angle    = 1'b0;
		path_chars     = 0;
		line_no        = 1;
		mismatch_count = 0;
		items_sent     = 0;
		gaps_on        = 1'b1;
		long_sent      = 1'b0;

		arst_n            <= 1'b0;
		text_in.valid     <= 1'b0;
		text_in.payload   <= '0;
		row_pinned        <= 1'b0;
		row_pinned_result <= '0;

		// Opening rows: an empty flushed line, an angle directive, a line broken
		// by a high byte, and a quoted directive with an empty path.
		opening_rows = '{
			'{'{8'hFF, 1'b1}, 1'b1, line_verdict(0, 0, 0, 1)},
			'{'{CH_HASH, 1'b0}, 1'b0, PREDICTED},
			'{'{"i", 1'b0}, 1'b0, PREDICTED},
			'{'{"n", 1'b0}, 1'b0, PREDICTED},
			'{'{"c", 1'b0}, 1'b0, PREDICTED},
			'{'{"l", 1'b0}, 1'b0, PREDICTED},
			'{'{"u", 1'b0}, 1'b0, PREDICTED},
			'{'{"d", 1'b0}, 1'b0, PREDICTED},
			'{'{"e", 1'b0}, 1'b0, PREDICTED},
			'{'{CH_LT, 1'b0}, 1'b0, PREDICTED},
			'{'{8'h80, 1'b0}, 1'b1, '{1'b1, 8'h80, 1'b0, 1'b0, 1'b0, 10'd0, 20'd0}},
			'{'{CH_GT, 1'b0}, 1'b0, PREDICTED},
			'{'{CH_NEWLINE, 1'b0}, 1'b1, line_verdict(1, 1, 1, 2)},
			'{'{8'hFF, 1'b0}, 1'b0, PREDICTED},
			'{'{CH_NEWLINE, 1'b0}, 1'b1, line_verdict(0, 0, 0, 3)},
			'{'{CH_HASH, 1'b0}, 1'b0, PREDICTED},
			'{'{"i", 1'b0}, 1'b0, PREDICTED},
			'{'{"n", 1'b0}, 1'b0, PREDICTED},
			'{'{"c", 1'b0}, 1'b0, PREDICTED},
			'{'{"l", 1'b0}, 1'b0, PREDICTED},
			'{'{"u", 1'b0}, 1'b0, PREDICTED},
			'{'{"d", 1'b0}, 1'b0, PREDICTED},
			'{'{"e", 1'b0}, 1'b0, PREDICTED},
			'{'{CH_QUOTE, 1'b0}, 1'b0, PREDICTED},
			'{'{CH_QUOTE, 1'b0}, 1'b0, PREDICTED},
			'{'{8'h00, 1'b1}, 1'b1, line_verdict(1, 0, 0, 4)}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_rows[i])
			send_item(opening_rows[i].item, opening_rows[i].pinned, opening_rows[i].result);

		// Hold the sender until the opening rows have all come back.
		drain_results();

		// Random lines; some stretches run without gaps on either side. One
		// long path runs beyond the cap of the path counter, which saturates there.
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			if (!long_sent && items_sent > RANDOM_ITEMS / 4) begin
				compose_directive(PATH_COUNT_LIMIT + 7);
				send_line();
				long_sent = 1'b1;
			end else begin
				random_line();
			end
		end

		// Last stretch, no gaps: flush lines back to back, then a few lines.
		gaps_on = 1'b0;
		drain_results();
		flushes_left = FINAL_FLUSHES;
		while (flushes_left > 0) begin
			send_flush(8'($urandom_range(0, 255)));
			flushes_left--;
		end
		repeat (10)
			random_line();

		drain_results();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
